[rtl/hbd4_pkg.sv]
// Shared constants, coefficient table and multiply-unit control types for the decimator.
`default_nettype none

package hbd4_pkg;

  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_STATE_BITS  = 28;
  localparam int COEF_BITS       = 24;
  localparam int COEF_SHIFT      = 22;
  localparam int NEW_SAMPLES     = 4;

  typedef enum logic [3:0] {
    CS_K0, CS_K1, CS_K2, CS_K3, CS_K4, CS_K5,
    CS_A0, CS_A1, CS_A2, CS_A3,
    CS_B0, CS_B1, CS_B2, CS_B3
  } coef_sel_e;

  typedef struct packed {
    logic      issue;
    logic      clr;
    coef_sel_e sel;
  } mac_op_t;

  function automatic logic signed [COEF_BITS-1:0] coef_of(input coef_sel_e sel);
    logic signed [COEF_BITS-1:0] c;
    unique case (sel)
      CS_K0:   c = 24'sd2097345;
      CS_K1:   c = 24'sd1279537;
      CS_K2:   c = -24'sd300569;
      CS_K3:   c = 24'sd84500;
      CS_K4:   c = -24'sd15595;
      CS_K5:   c = 24'sd607;
      CS_A0:   c = 24'sd1699747;
      CS_A1:   c = 24'sd6536002;
      CS_A2:   c = 24'sd2974538;
      CS_A3:   c = 24'sd7356974;
      CS_B0:   c = 24'sd74906;
      CS_B1:   c = 24'sd2499874;
      CS_B2:   c = 24'sd403482;
      CS_B3:   c = 24'sd3195493;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/hbd4_mac.sv]
// Shared pipelined multiply, floor-shift and accumulate unit.
`default_nettype none

module hbd4_mac #(
  parameter int SAMPLE_BITS = hbd4_pkg::DEF_SAMPLE_BITS,
  parameter int STATE_BITS  = hbd4_pkg::DEF_STATE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hbd4_pkg::mac_op_t     op_i,
  input  wire logic signed [((SAMPLE_BITS + 1 > STATE_BITS) ? SAMPLE_BITS + 1 : STATE_BITS)-1:0]
                                     opnd_i,
  output logic signed [((SAMPLE_BITS + 1 > STATE_BITS) ? SAMPLE_BITS + 1 : STATE_BITS) + 2:0]
                                     acc_o
);

  localparam int MUL_BITS  = (SAMPLE_BITS + 1 > STATE_BITS) ? SAMPLE_BITS + 1 : STATE_BITS;
  localparam int ACC_BITS  = MUL_BITS + 3;
  localparam int PROD_BITS = hbd4_pkg::COEF_BITS + MUL_BITS;

  logic                                   v0_q, v1_q;
  logic                                   c0_q, c1_q;
  logic signed [hbd4_pkg::COEF_BITS-1:0]  coef_q;
  logic signed [MUL_BITS-1:0]             opnd_q;
  logic signed [PROD_BITS-1:0]            prod_q;
  logic signed [ACC_BITS-1:0]             acc_q;
  logic signed [PROD_BITS-1:0]            shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= op_i.issue;
      v1_q <= v0_q;
    end
  end

  assign shifted = prod_q >>> hbd4_pkg::COEF_SHIFT;

  always_ff @(posedge clk_i) begin
    if (op_i.issue) begin
      coef_q <= hbd4_pkg::coef_of(op_i.sel);
      opnd_q <= opnd_i;
      c0_q   <= op_i.clr;
    end
    if (v0_q) begin
      prod_q <= PROD_BITS'(coef_q) * PROD_BITS'(opnd_q);
      c1_q   <= c0_q;
    end
    if (v1_q) begin
      acc_q <= (c1_q ? ACC_BITS'(0) : acc_q) + ACC_BITS'(shifted);
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[rtl/hbd4_core.sv]
// Step sequencer, sample history and filter state around the shared multiply unit.
`default_nettype none

module hbd4_core #(
  parameter int SAMPLE_BITS = hbd4_pkg::DEF_SAMPLE_BITS,
  parameter int STATE_BITS  = hbd4_pkg::DEF_STATE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [SAMPLE_BITS-1:0] samples_i [hbd4_pkg::NEW_SAMPLES],
  input  wire logic                          out_free_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic signed [SAMPLE_BITS-1:0]      y_o
);

  localparam int MUL_BITS = (SAMPLE_BITS + 1 > STATE_BITS) ? SAMPLE_BITS + 1 : STATE_BITS;
  localparam int ACC_BITS = MUL_BITS + 3;
  localparam int HIST_LEN = 17;
  localparam int WIN_LEN  = HIST_LEN + hbd4_pkg::NEW_SAMPLES;
  localparam int AP_REGS  = 8;

  typedef enum logic [4:0] {
    S_AP2_A, S_AP2_B,
    S_FA_0, S_FA_1, S_FA_2, S_FA_3, S_FA_4, S_FA_5,
    S_FB_0, S_FB_1, S_FB_2, S_FB_3, S_FB_4, S_FB_5,
    S_AP0_A, S_AP0_B, S_AP3_A, S_AP3_B, S_AP0_WB,
    S_AP1_A, S_AP1_B, S_WAIT_0, S_WAIT_1, S_FINISH,
    S_IDLE
  } step_e;

  step_e                          step_q;
  logic signed [SAMPLE_BITS-1:0]  hist_q [HIST_LEN];
  logic signed [SAMPLE_BITS-1:0]  nw_q   [hbd4_pkg::NEW_SAMPLES];
  logic signed [SAMPLE_BITS-1:0]  win    [WIN_LEN];
  logic signed [STATE_BITS-1:0]   st_q   [AP_REGS];
  logic signed [STATE_BITS-1:0]   delay_q, pa_q, y0_q, y2_q, y3_q;
  logic signed [STATE_BITS-1:0]   t_w, y1_w;
  logic signed [ACC_BITS-1:0]     acc;
  logic signed [MUL_BITS-1:0]     opnd;
  hbd4_pkg::mac_op_t              op;

  function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [ACC_BITS-1:0] v);
    logic [ACC_BITS-STATE_BITS:0] top;
    top = v[ACC_BITS-1:STATE_BITS-1];
    if (&top || ~|top) begin
      return v[STATE_BITS-1:0];
    end
    return v[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [ACC_BITS-1:0] v);
    logic [ACC_BITS-SAMPLE_BITS:0] top;
    top = v[ACC_BITS-1:SAMPLE_BITS-1];
    if (&top || ~|top) begin
      return v[SAMPLE_BITS-1:0];
    end
    return v[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [STATE_BITS-1:0] add_st(
    input logic signed [STATE_BITS-1:0] a,
    input logic signed [STATE_BITS-1:0] b
  );
    return sat_st(ACC_BITS'(a) + ACC_BITS'(b));
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sub_st(
    input logic signed [STATE_BITS-1:0] a,
    input logic signed [STATE_BITS-1:0] b
  );
    return sat_st(ACC_BITS'(a) - ACC_BITS'(b));
  endfunction

  function automatic logic signed [MUL_BITS-1:0] pair(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    return MUL_BITS'(a) + MUL_BITS'(b);
  endfunction

  always_comb begin
    for (int i = 0; i < HIST_LEN; i++) begin
      win[i] = hist_q[i];
    end
    for (int i = 0; i < hbd4_pkg::NEW_SAMPLES; i++) begin
      win[HIST_LEN + i] = nw_q[i];
    end
  end

  assign t_w  = sat_st(acc);
  assign y1_w = add_st(st_q[3], t_w);

  always_comb begin
    op.issue = 1'b1;
    op.clr   = 1'b0;
    op.sel   = hbd4_pkg::CS_K0;
    opnd     = '0;
    unique case (step_q)
      S_AP2_A:  begin op.clr = 1'b1; op.sel = hbd4_pkg::CS_A2; opnd = MUL_BITS'(st_q[4]); end
      S_AP2_B:  begin op.sel = hbd4_pkg::CS_B2; opnd = MUL_BITS'(add_st(delay_q, st_q[5])); end
      S_FA_0:   begin op.clr = 1'b1; opnd = MUL_BITS'(win[9]); end
      S_FA_1:   begin op.sel = hbd4_pkg::CS_K1; opnd = pair(win[8], win[10]); end
      S_FA_2:   begin op.sel = hbd4_pkg::CS_K2; opnd = pair(win[6], win[12]); end
      S_FA_3:   begin op.sel = hbd4_pkg::CS_K3; opnd = pair(win[4], win[14]); end
      S_FA_4:   begin op.sel = hbd4_pkg::CS_K4; opnd = pair(win[2], win[16]); end
      S_FA_5:   begin op.sel = hbd4_pkg::CS_K5; opnd = pair(win[0], win[18]); end
      S_FB_0:   begin op.clr = 1'b1; opnd = MUL_BITS'(win[11]); end
      S_FB_1:   begin op.sel = hbd4_pkg::CS_K1; opnd = pair(win[10], win[12]); end
      S_FB_2:   begin op.sel = hbd4_pkg::CS_K2; opnd = pair(win[8], win[14]); end
      S_FB_3:   begin op.sel = hbd4_pkg::CS_K3; opnd = pair(win[6], win[16]); end
      S_FB_4:   begin op.sel = hbd4_pkg::CS_K4; opnd = pair(win[4], win[18]); end
      S_FB_5:   begin op.sel = hbd4_pkg::CS_K5; opnd = pair(win[2], win[20]); end
      S_AP0_A:  begin op.clr = 1'b1; op.sel = hbd4_pkg::CS_A0; opnd = MUL_BITS'(st_q[0]); end
      S_AP0_B:  begin op.sel = hbd4_pkg::CS_B0; opnd = MUL_BITS'(add_st(pa_q, st_q[1])); end
      S_AP3_A:  begin op.clr = 1'b1; op.sel = hbd4_pkg::CS_A3; opnd = MUL_BITS'(st_q[6]); end
      S_AP3_B:  begin op.sel = hbd4_pkg::CS_B3; opnd = MUL_BITS'(add_st(y2_q, st_q[7])); end
      S_AP1_A:  begin op.clr = 1'b1; op.sel = hbd4_pkg::CS_A1; opnd = MUL_BITS'(st_q[2]); end
      S_AP1_B:  begin op.sel = hbd4_pkg::CS_B1; opnd = MUL_BITS'(add_st(y0_q, st_q[3])); end
      default:  op.issue = 1'b0;
    endcase
  end

  hbd4_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .opnd_i (opnd),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= S_IDLE;
      delay_q <= '0;
      pa_q    <= '0;
      y0_q    <= '0;
      y2_q    <= '0;
      y3_q    <= '0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_q[i] <= '0;
      end
      for (int i = 0; i < hbd4_pkg::NEW_SAMPLES; i++) begin
        nw_q[i] <= '0;
      end
      for (int i = 0; i < AP_REGS; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      unique case (step_q)
        S_IDLE: begin
          if (start_i) begin
            step_q <= S_AP2_A;
            for (int i = 0; i < hbd4_pkg::NEW_SAMPLES; i++) begin
              nw_q[i] <= samples_i[i];
            end
          end
        end
        S_FINISH: begin
          if (out_free_i) begin
            step_q  <= S_IDLE;
            st_q[3] <= st_q[2];
            st_q[2] <= sub_st(y0_q, t_w);
            for (int i = 0; i < HIST_LEN; i++) begin
              hist_q[i] <= win[i + hbd4_pkg::NEW_SAMPLES];
            end
          end
        end
        default: begin
          step_q <= step_e'(step_q + 5'd1);
          if (step_q == S_FA_2) begin
            y2_q    <= add_st(st_q[5], t_w);
            st_q[5] <= st_q[4];
            st_q[4] <= sub_st(delay_q, t_w);
          end
          if (step_q == S_FB_2) begin
            pa_q <= t_w;
          end
          if (step_q == S_AP3_A) begin
            delay_q <= t_w;
          end
          if (step_q == S_AP0_WB) begin
            y0_q    <= add_st(st_q[1], t_w);
            st_q[1] <= st_q[0];
            st_q[0] <= sub_st(pa_q, t_w);
          end
          if (step_q == S_AP1_B) begin
            y3_q    <= add_st(st_q[7], t_w);
            st_q[7] <= st_q[6];
            st_q[6] <= sub_st(y2_q, t_w);
          end
        end
      endcase
    end
  end

  assign busy_o = (step_q != S_IDLE);
  assign done_o = (step_q == S_FINISH) && out_free_i;
  assign y_o    = sat_smp(ACC_BITS'(y1_w) + ACC_BITS'(y3_q));

endmodule

`default_nettype wire

[rtl/halfband_decimator_by_four.sv]
// Top level: stream handshake, input unpacking and output register of the decimator.
// Flow: an input transaction starts 24 sequencer steps that feed the single shared
// multiplier (20 multiplies); the result then goes to the output register, and no new
// input is accepted until that hand-over is done.
// A waiting result stalls only the last step; the next input is not taken meanwhile.
// Reset: rst_ni clears the history, allpass states, phase delay and all handshakes.
`default_nettype none

module halfband_decimator_by_four #(
  parameter int SAMPLE_BITS = hbd4_pkg::DEF_SAMPLE_BITS,
  parameter int STATE_BITS  = hbd4_pkg::DEF_STATE_BITS
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           s_axis_tvalid,
  output logic                                                s_axis_tready,
  // sample_0, sample_1, sample_2, sample_3 (SAMPLE_BITS each), zero pad
  input  wire logic [((hbd4_pkg::NEW_SAMPLES * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                                m_axis_tvalid,
  input  wire logic                                           m_axis_tready,
  // out_sample (SAMPLE_BITS), zero pad
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]            m_axis_tdata
);

  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  logic signed [SAMPLE_BITS-1:0] samples [hbd4_pkg::NEW_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] y;
  logic [SAMPLE_BITS-1:0]        out_q;
  logic                          ovalid_q;
  logic                          busy, done, start, out_free;

  always_comb begin
    for (int i = 0; i < hbd4_pkg::NEW_SAMPLES; i++) begin
      samples[i] = $signed(s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;

  hbd4_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .samples_i  (samples),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .y_o        (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (done) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= y;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(out_q);

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the decimate-by-four halfband filter with a bit-exact predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int SAMPLE_W       = hbd4_pkg::DEF_SAMPLE_BITS;
  localparam int STATE_W        = hbd4_pkg::DEF_STATE_BITS;
  localparam int HIST_LEN       = 17;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [4*SAMPLE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;

  halfband_decimator_by_four uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic signed [SAMPLE_W-1:0] fir_hist [HIST_LEN];
  logic signed [STATE_W-1:0]  ap_state [8];
  logic signed [STATE_W-1:0]  pb_delay;
  longint                     window [HIST_LEN + 4];

  logic [SAMPLE_W-1:0] expected_out [$];
  int mismatches = 0;
  int items_in = 0;
  int results_checked = 0;
  int idle_cycles = 0;

  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint scale(input longint c, input longint v);
    return (c * v) >>> hbd4_pkg::COEF_SHIFT;
  endfunction

  function automatic longint hb_tap(input int k);
    case (k)
      0:       return 2097345;
      1:       return 1279537;
      2:       return -300569;
      3:       return 84500;
      4:       return -15595;
      default: return 607;
    endcase
  endfunction

  function automatic longint ap_coef_a(input int sec);
    case (sec)
      0:       return 1699747;
      1:       return 6536002;
      2:       return 2974538;
      default: return 7356974;
    endcase
  endfunction

  function automatic longint ap_coef_b(input int sec);
    case (sec)
      0:       return 74906;
      1:       return 2499874;
      2:       return 403482;
      default: return 3195493;
    endcase
  endfunction

  function automatic longint halfband_at(input int c);
    longint acc;
    int k;
    int d;
    acc = scale(hb_tap(0), window[c]);
    acc += scale(hb_tap(1), window[c+1] + window[c-1]);
    for (k = 2; k < 6; k++) begin
      d = 2 * k - 1;
      acc += scale(hb_tap(k), window[c+d] + window[c-d]);
    end
    return clamp(acc, STATE_W);
  endfunction

  function automatic longint allpass_section(input longint x, input int sec);
    longint s1;
    longint s2;
    longint t;
    longint y;
    s1 = longint'(ap_state[2*sec]);
    s2 = longint'(ap_state[2*sec+1]);
    t = clamp(scale(ap_coef_a(sec), s1) + scale(ap_coef_b(sec), clamp(x + s2, STATE_W)),
              STATE_W);
    y = clamp(s2 + t, STATE_W);
    ap_state[2*sec+1] = ap_state[2*sec];
    ap_state[2*sec] = STATE_W'(clamp(x - t, STATE_W));
    return y;
  endfunction

  function automatic logic [SAMPLE_W-1:0] advance_decimator(input logic [4*SAMPLE_W-1:0] quad);
    longint pa;
    longint pb;
    longint xb;
    longint ya;
    longint yb;
    int i;
    for (i = 0; i < HIST_LEN; i++) window[i] = longint'(fir_hist[i]);
    for (i = 0; i < 4; i++) window[HIST_LEN+i] = longint'($signed(quad[i*SAMPLE_W +: SAMPLE_W]));
    pa = halfband_at(9);
    pb = halfband_at(11);
    for (i = 0; i < HIST_LEN; i++) fir_hist[i] = SAMPLE_W'(window[i+4]);
    ya = allpass_section(allpass_section(pa, 0), 1);
    xb = longint'(pb_delay);
    pb_delay = STATE_W'(pb);
    yb = allpass_section(allpass_section(xb, 2), 3);
    return SAMPLE_W'(clamp(ya + yb, SAMPLE_W));
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_out.push_back(advance_decimator(s_axis_tdata));
        items_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          note_error($sformatf("out_sample 0x%06h with no result pending", m_axis_tdata));
        end else begin
          want = expected_out.pop_front();
          results_checked++;
          if (m_axis_tdata !== want)
            note_error($sformatf("out_sample #%0d expected 0x%06h got 0x%06h",
                                 results_checked, want, m_axis_tdata));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: %0d cycles without a transaction", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random stalls plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls_on && stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_samples(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                              input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d);
    int gap;
    int r;
    gap = 0;
    if (src_gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 55)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else             gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, c, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic test_zero_input();
    repeat (2) send_samples('0, '0, '0, '0);
  endtask

  task automatic test_extremes();
    send_samples(FULL_POS, FULL_POS, FULL_POS, FULL_POS);
    send_samples(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG);
    send_samples(FULL_POS, FULL_NEG, FULL_POS, FULL_NEG);
    send_samples(FULL_NEG, FULL_POS, FULL_NEG, FULL_POS);
    send_samples(24'h000001, 24'hffffff, 24'h000001, 24'hffffff);
    send_samples(24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa);
  endtask

  task automatic test_impulse();
    send_samples(FULL_POS, '0, '0, '0);
    repeat (4) send_samples('0, '0, '0, '0);
  endtask

  task automatic test_dc_saturation();
    repeat (5) send_samples(FULL_POS, FULL_POS, FULL_POS, FULL_POS);
    repeat (5) send_samples(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG);
  endtask

  task automatic test_backpressure();
    int n;
    src_gaps_on = 1'b0;
    hold_req++;
    for (n = 0; n < 30; n++)
      send_samples(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                   SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int sent;
    int kind;
    int seg_len;
    int n;
    logic [SAMPLE_W-1:0] lvl;
    logic [SAMPLE_W-1:0] neg_lvl;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      seg_len = $urandom_range(5, 40);
      src_gaps_on = ($urandom_range(0, 4) != 0);
      sink_stalls_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 4))
        0:       lvl = FULL_POS;
        1:       lvl = FULL_NEG;
        default: lvl = SAMPLE_W'($urandom());
      endcase
      neg_lvl = -lvl;
      for (n = 0; n < seg_len; n++) begin
        if (kind < 45) begin
          send_samples(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                       SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        end else if (kind < 65) begin
          send_samples(SAMPLE_W'($urandom_range(0, 8191) - 4096),
                       SAMPLE_W'($urandom_range(0, 8191) - 4096),
                       SAMPLE_W'($urandom_range(0, 8191) - 4096),
                       SAMPLE_W'($urandom_range(0, 8191) - 4096));
        end else if (kind < 80) begin
          send_samples(lvl, lvl, lvl, lvl);
        end else if (kind < 90) begin
          send_samples(lvl, '0, neg_lvl, '0);
        end else begin
          send_samples(lvl, neg_lvl, lvl, neg_lvl);
        end
      end
      sent += seg_len;
    end
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    int i;
    for (i = 0; i < HIST_LEN; i++) fir_hist[i] = '0;
    for (i = 0; i < 8; i++) ap_state[i] = '0;
    pb_delay = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_input();
    test_extremes();
    test_impulse();
    test_dc_saturation();
    test_backpressure();
    test_random();

    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input transactions and %0d output samples: extremes, impulse,",
             items_in, results_checked);
    $display("DC saturation, tones, random data, gaps, stalls and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
